### rtl/core/sorted_table_range_search_top_defines.svh
// Assertion macros of the sorted table range search RTL, used by srs_ctrl.
`ifndef SORTED_TABLE_RANGE_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_RANGE_SEARCH_TOP_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define SRS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// post must hold in the cycle after pre
`define SRS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/core/srs_pkg.sv
// Shared types and constants of the sorted table range search block.
package srs_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned OUT_W       = 11;
  localparam int unsigned TDATA_IN_W  = 32;
  localparam int unsigned TUSER_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 56;

  localparam logic [OUT_W-1:0] NONE_POS = {OUT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef struct packed {
    logic done;
    logic found;
  } srs_stat_t;

endpackage

### rtl/core/sorted_table_range_search_top.sv
// Top level of the sorted table range search: stream ports, RAM, search control, result register.
//
// Channel  Dir  Handshake                  Payload
// s_axis   in   s_axis_tvalid/tready       tuser: operation; tdata: item_value
// m_axis   out  m_axis_tvalid/tready       tdata: query result fields
//
// Clear and append complete in the idle state as they are accepted. A query runs two searches,
// the lower and the upper bound, of at most ceil(log2(len+1)) probes each, then a done state.
// Each probe is a registered read of the single RAM port, then a compare.
// Reset empties the table through the length register; the RAM is not cleared.
// The result register frees the search while a result waits; a full register holds the next
// query in its done state, and no new input is accepted until that result is taken.
module sorted_table_range_search_top import srs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [31:0] item_value
  input  logic [TUSER_IN_W-1:0]  s_axis_tuser,  // [1:0] operation, [7:2] zero
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [10:0] lower_index, [21:11] upper_index, [22] found, [33:23] first_position,
  // [44:34] last_position, [55:45] occurrence_count
  output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned LW    = $clog2(TABLE_DEPTH + 1);

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic signed [VAL_W-1:0] rd_data;
  srs_stat_t               stat;
  logic [LW-1:0]           lb;
  logic [LW-1:0]           ub;
  logic                    take;

  logic                   m_valid_q;
  logic [TDATA_OUT_W-1:0] m_data_q;
  logic [OUT_W-1:0]       lb_f, ub_f, first_f, last_f, count_f;

  srs_mem #(
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  srs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW),
    .LW         (LW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .op_i      (op_e'(s_axis_tuser[OP_W-1:0])),
    .value_i   ($signed(s_axis_tdata[VAL_W-1:0])),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .stat_o    (stat),
    .lb_o      (lb),
    .ub_o      (ub),
    .take_i    (take)
  );

  assign take    = stat.done && (!m_valid_q || m_axis_tready);
  assign lb_f    = OUT_W'(lb);
  assign ub_f    = OUT_W'(ub);
  assign first_f = stat.found ? lb_f : NONE_POS;
  assign last_f  = stat.found ? OUT_W'(ub - LW'(1)) : NONE_POS;
  assign count_f = stat.found ? OUT_W'(ub - lb) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (take) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      m_data_q <= {count_f, last_f, first_f, stat.found, ub_f, lb_f};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### rtl/core/srs_mem.sv
// Element store: single-port write, single-port registered read RAM.
module srs_mem import srs_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [AW-1:0]           wr_addr_i,
  input  logic signed [VAL_W-1:0] wr_data_i,
  input  logic                    rd_en_i,
  input  logic [AW-1:0]           rd_addr_i,
  output logic signed [VAL_W-1:0] rd_data_o
);

  logic signed [VAL_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### rtl/core/srs_ctrl.sv
// Table length, command decode and the two bound searches over the element store.
`include "sorted_table_range_search_top_defines.svh"

module srs_ctrl import srs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned AW          = 10,
  parameter int unsigned LW          = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  op_e                     op_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    wr_en_o,
  output logic [AW-1:0]           wr_addr_o,
  output logic signed [VAL_W-1:0] wr_data_o,
  output logic                    rd_en_o,
  output logic [AW-1:0]           rd_addr_o,
  input  logic signed [VAL_W-1:0] rd_data_i,
  output srs_stat_t               stat_o,
  output logic [LW-1:0]           lb_o,
  output logic [LW-1:0]           ub_o,
  input  logic                    take_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOP = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] low_q, low_d;
  logic [LW-1:0] hi_q, hi_d;
  logic [LW-1:0] ans_q, ans_d;
  logic [LW-1:0] mid_q, mid_d;
  logic [LW-1:0] lb_q, lb_d;
  logic [LW-1:0] ub_q, ub_d;
  logic          strict_q, strict_d;
  logic          eq_q, eq_d;
  logic          found_q, found_d;
  logic signed [VAL_W-1:0] target_q, target_d;

  logic [LW-1:0] span;
  logic [LW-1:0] mid;
  logic          go_left;

  // hi is exclusive: probe at low + (hi - 1 - low) / 2
  assign span    = hi_q - low_q - LW'(1);
  assign mid     = low_q + (span >> 1);
  assign go_left = strict_q ? (rd_data_i > target_q) : (rd_data_i >= target_q);

  assign in_ready_o   = (state_q == ST_IDLE);
  assign wr_addr_o    = AW'(len_q);
  assign wr_data_o    = value_i;
  assign rd_addr_o    = AW'(mid);
  assign stat_o.done  = (state_q == ST_DONE);
  assign stat_o.found = found_q;
  assign lb_o         = lb_q;
  assign ub_o         = ub_q;

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    low_d    = low_q;
    hi_d     = hi_q;
    ans_d    = ans_q;
    mid_d    = mid_q;
    lb_d     = lb_q;
    ub_d     = ub_q;
    strict_d = strict_q;
    eq_d     = eq_q;
    found_d  = found_q;
    target_d = target_q;
    wr_en_o  = 1'b0;
    rd_en_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_CLEAR: begin
              len_d = '0;
            end
            OP_APPEND: begin
              if (len_q < LW'(TABLE_DEPTH)) begin
                wr_en_o = 1'b1;
                len_d   = len_q + LW'(1);
              end
            end
            OP_QUERY: begin
              target_d = value_i;
              low_d    = '0;
              hi_d     = len_q;
              ans_d    = len_q;
              strict_d = 1'b0;
              eq_d     = 1'b0;
              state_d  = ST_LOOP;
            end
            default: ;
          endcase
        end
      end
      ST_LOOP: begin
        if (low_q < hi_q) begin
          rd_en_o = 1'b1;
          mid_d   = mid;
          state_d = ST_EVAL;
        end else if (!strict_q) begin
          lb_d     = ans_q;
          found_d  = eq_q;
          low_d    = '0;
          hi_d     = len_q;
          ans_d    = len_q;
          strict_d = 1'b1;
        end else begin
          ub_d    = ans_q;
          state_d = ST_DONE;
        end
      end
      ST_EVAL: begin
        if (go_left) begin
          ans_d = mid_q;
          hi_d  = mid_q;
          if (!strict_q) begin
            eq_d = (rd_data_i == target_q);
          end
        end else begin
          low_d = mid_q + LW'(1);
        end
        state_d = ST_LOOP;
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q    <= low_d;
    hi_q     <= hi_d;
    ans_q    <= ans_d;
    mid_q    <= mid_d;
    lb_q     <= lb_d;
    ub_q     <= ub_d;
    strict_q <= strict_d;
    eq_q     <= eq_d;
    found_q  <= found_d;
    target_q <= target_d;
  end

  `SRS_ASSERT_ALWAYS(a_len_bounded, len_q <= LW'(TABLE_DEPTH), "table length past depth")
  `SRS_ASSERT_ALWAYS(a_probe_in_table, !rd_en_o || (LW'(rd_addr_o) < len_q),
                     "probe outside filled table")
  `SRS_ASSERT_ALWAYS(a_found_span, !stat_o.done || !found_q || (ub_q > lb_q),
                     "found with empty occurrence span")
  `SRS_ASSERT_NEXT(a_query_starts, in_valid_i && in_ready_o && (op_i == OP_QUERY),
                   state_q == ST_LOOP, "query did not start a search")

endmodule

### tb/sv/range_search_checker.sv
// Checker for the sorted table range search: keeps a copy of the table, predicts and compares query results.
module range_search_checker import srs_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [31:0] item_value
  input  logic [TUSER_IN_W-1:0]  s_axis_tuser,  // [1:0] operation, [7:2] zero
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [10:0] lower_index, [21:11] upper_index, [22] found, [33:23] first_position,
  // [44:34] last_position, [55:45] occurrence_count
  input  logic [TDATA_OUT_W-1:0] m_axis_tdata,
  output int                     mismatch_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_W-1:0] count;
    logic [OUT_W-1:0] last_pos;
    logic [OUT_W-1:0] first_pos;
    logic             found;
    logic [OUT_W-1:0] upper;
    logic [OUT_W-1:0] lower;
  } query_result_t;

  logic signed [VAL_W-1:0] table_mem [TABLE_DEPTH];
  int                      table_len;
  query_result_t           expected_results [$];
  int                      mismatch_count;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = expected_results.size();

  // strict: first index with element > target, else first with element >= target
  function automatic int bound_index(logic signed [VAL_W-1:0] target, bit strict);
    int lo;
    int hi;
    int mid;
    int idx;
    lo  = 0;
    hi  = table_len - 1;
    idx = table_len;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (strict ? (table_mem[mid] > target) : (table_mem[mid] >= target)) begin
        idx = mid;
        hi  = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return idx;
  endfunction

  function automatic query_result_t predict_query(logic signed [VAL_W-1:0] target);
    query_result_t r;
    int            lb;
    int            ub;
    int            last_idx;
    int            span;
    bit            hit;
    lb       = bound_index(target, 1'b0);
    ub       = bound_index(target, 1'b1);
    hit      = (lb < table_len) && (table_mem[lb] == target);
    last_idx = ub - 1;
    span     = ub - lb;
    r.lower     = lb[OUT_W-1:0];
    r.upper     = ub[OUT_W-1:0];
    r.found     = hit;
    r.first_pos = hit ? lb[OUT_W-1:0] : NONE_POS;
    r.last_pos  = hit ? last_idx[OUT_W-1:0] : NONE_POS;
    r.count     = hit ? span[OUT_W-1:0] : '0;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      if (mismatch_count < 10) begin
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    query_result_t           got;
    query_result_t           want;
    logic signed [VAL_W-1:0] value;
    if (!rst_ni) begin
      expected_results.delete();
      table_len      = 0;
      mismatch_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result with no query pending, tdata %h", $time, m_axis_tdata);
          end
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("lower_index", want.lower, got.lower);
          check_field("upper_index", want.upper, got.upper);
          check_field("found", want.found, got.found);
          check_field("first_position", want.first_pos, got.first_pos);
          check_field("last_position", want.last_pos, got.last_pos);
          check_field("occurrence_count", want.count, got.count);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        value = s_axis_tdata[VAL_W-1:0];
        case (s_axis_tuser[OP_W-1:0])
          OP_CLEAR: begin
            table_len = 0;
          end
          OP_APPEND: begin
            if (table_len < TABLE_DEPTH) begin
              table_mem[table_len] = value;
              table_len++;
            end
          end
          OP_QUERY: begin
            expected_results.push_back(predict_query(value));
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the sorted table range search: clock, reset, stimulus, watchdog and verdict.
module tb_top import srs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              DEPTH        = 1024;
  localparam int              ITEM_TARGET  = 1700;
  localparam int              CALM_FROM    = 1450;
  localparam int              FULL_FROM    = 300;
  localparam int              HOLD_CYCLES  = 400;
  localparam int              STALL_LIMIT  = 4000;
  localparam int              DRAIN_CYCLES = 80;
  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam longint          VAL_MIN      = -64'sd2147483648;
  localparam longint          VAL_MAX      = 64'sd2147483647;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;  // [31:0] item_value
  logic [TUSER_IN_W-1:0]  s_axis_tuser  = '0;  // [1:0] operation, [7:2] zero
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [10:0] lower_index, [21:11] upper_index, [22] found, [33:23] first_position,
  // [44:34] last_position, [55:45] occurrence_count
  logic [TDATA_OUT_W-1:0] m_axis_tdata;

  int  mismatches;
  int  pending;
  int  items_sent  = 0;
  int  idle_cycles = 0;
  bit  calm        = 1'b0;
  bit  hold_req    = 1'b0;
  bit  hold_done   = 1'b0;
  bit  full_done   = 1'b0;
  logic signed [VAL_W-1:0] table_copy [$];

  always #6 clk_i = ~clk_i;

  sorted_table_range_search_top #(.TABLE_DEPTH(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  range_search_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result sink: random ready bursts, one long hold-off on request
  initial begin : sink
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] value);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= {{(TUSER_IN_W-OP_W){1'b0}}, op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != OP_UNUSED) items_sent++;
    if (op == OP_CLEAR) table_copy.delete();
    if (op == OP_APPEND && table_copy.size() < DEPTH) table_copy.push_back(value);
    @(negedge clk_i);
  endtask

  function automatic longint clamp_value(longint v);
    return (v > VAL_MAX) ? VAL_MAX : ((v < VAL_MIN) ? VAL_MIN : v);
  endfunction

  function automatic logic [VAL_W-1:0] pick_target();
    logic signed [VAL_W-1:0] r;
    longint                  t;
    int                      pick;
    int                      idx;
    pick = $urandom_range(0, 6);
    if (table_copy.size() == 0 && pick < 3) pick = 4;
    idx = (table_copy.size() == 0) ? 0 : $urandom_range(0, table_copy.size() - 1);
    r   = $urandom;
    case (pick)
      0:       t = table_copy[idx];
      1:       t = clamp_value(longint'(table_copy[idx]) + 1);
      2:       t = clamp_value(longint'(table_copy[idx]) - 1);
      3:       t = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      6:       t = longint'($urandom_range(0, 200)) - 100;
      default: t = r;
    endcase
    return t[VAL_W-1:0];
  endfunction

  // one table build followed by queries; mostly sorted, sometimes not
  task automatic run_phase(bit full_fill);
    longint cur;
    longint step_hi;
    int     len;
    int     mode;
    int     zero_pct;
    int     n_queries;
    bit     unsorted;
    if (full_fill || $urandom_range(0, 5) != 0) send_item(OP_CLEAR, $urandom);
    mode     = full_fill ? 0 : $urandom_range(0, 2);
    len      = full_fill ? DEPTH + 6 :
               (($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 16));
    zero_pct = full_fill ? 62 : 16;
    unsorted = !full_fill && ($urandom_range(0, 9) == 0);
    case (mode)
      0: begin
        cur     = longint'($urandom_range(0, 200)) - 100;
        step_hi = 2;
      end
      1: begin
        cur     = longint'($urandom_range(0, 2000000)) - 1000000;
        step_hi = 1000;
      end
      default: begin
        cur     = VAL_MIN + $urandom_range(0, 1000);
        step_hi = 64'sd4294967296 / (len + 1);
        if (step_hi > 64'sd4294967295) step_hi = 64'sd4294967295;
      end
    endcase
    for (int i = 0; i < len; i++) begin
      if (unsorted) begin
        cur = longint'($urandom_range(0, 40)) - 20;
      end else if (i > 0 && $urandom_range(0, 63) >= zero_pct) begin
        cur = clamp_value(cur + $urandom_range(1, int'(step_hi)));
      end
      send_item(OP_APPEND, cur[VAL_W-1:0]);
      if (!full_fill && $urandom_range(0, 19) == 0) send_item(OP_UNUSED, $urandom);
    end
    n_queries = full_fill ? 40 : $urandom_range(1, 8);
    for (int i = 0; i < n_queries; i++) begin
      send_item(OP_QUERY, pick_target());
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table, ignored code, then a sorted table with extremes and duplicates
    send_item(OP_QUERY, 32'd0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    send_item(OP_APPEND, 32'h8000_0000);
    send_item(OP_APPEND, -32'sd5);
    send_item(OP_APPEND, -32'sd5);
    send_item(OP_APPEND, -32'sd5);
    send_item(OP_APPEND, 32'd0);
    send_item(OP_APPEND, 32'd7);
    send_item(OP_APPEND, 32'h7FFF_FFFF);
    send_item(OP_QUERY, 32'h8000_0000);
    send_item(OP_QUERY, -32'sd5);
    send_item(OP_QUERY, -32'sd6);
    send_item(OP_QUERY, 32'd0);
    send_item(OP_QUERY, 32'd6);
    send_item(OP_QUERY, 32'h7FFF_FFFF);
    send_item(OP_QUERY, 32'h7FFF_FFFE);
    send_item(OP_QUERY, 32'd100);
    // unsorted table
    send_item(OP_CLEAR, 32'hFFFF_FFFF);
    send_item(OP_APPEND, 32'd5);
    send_item(OP_APPEND, 32'd1);
    send_item(OP_APPEND, 32'd9);
    send_item(OP_APPEND, 32'd3);
    send_item(OP_QUERY, 32'd3);
    send_item(OP_QUERY, 32'd9);

    hold_req = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= CALM_FROM);
      if (!full_done && items_sent >= FULL_FROM) begin
        run_phase(1'b1);
        full_done = 1'b1;
      end else begin
        run_phase(1'b0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
